@@ hdl/rssa_pkg.sv @@
// Shared types and constants for the ring slot span allocator.
`timescale 1ns / 1ps
`default_nettype none

package rssa_pkg;

   // Ring geometry (slot count is a power of two)
   localparam int POOL_SLOTS = 1024;
   localparam int MAX_SPAN   = 16;
   localparam int ADDR_W     = $clog2(POOL_SLOTS);

   // Fixed field widths of the channels
   localparam int CMD_W  = 3;
   localparam int IDX_W  = 16;
   localparam int CNT_W  = 8;
   localparam int STAT_W = 3;
   localparam int POS_W  = 10;
   localparam int WIDE_W = IDX_W + 1;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [WIDE_W-1:0] wide_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [STAT_W-1:0] stat_code_type;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RECYCLE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CHECK    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ROLLBACK = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RESET    = 3'd5;

   // Status codes
   localparam stat_code_type ST_OK     = 3'd0;
   localparam stat_code_type ST_COUNT  = 3'd1;
   localparam stat_code_type ST_FULL   = 3'd2;
   localparam stat_code_type ST_INDEX  = 3'd3;
   localparam stat_code_type ST_EMPTY  = 3'd4;
   localparam stat_code_type ST_FREED  = 3'd5;
   localparam stat_code_type ST_OWNER  = 3'd6;
   localparam stat_code_type ST_TARGET = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [IDX_W-1:0] slot_index;
      logic [CNT_W-1:0] sqe_count;
   } req_type;

   typedef struct packed {
      stat_code_type status;
      pos_type       position;
      pos_type       head_now;
      pos_type       tail_now;
      pos_type       pending_count;
   } rsp_type;

   // One slot entry: free flag and owner start slot
   typedef struct packed {
      logic     free;
      addr_type owner;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller to datapath commands
   typedef struct packed {
      logic latch_req;
      logic commit_dec;
      logic clear_step;
      logic alloc_step;
      logic free_step;
      logic look_commit;
      logic load_rsp;
   } ctl_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic alloc_last;
      logic free_last;
      logic go_alloc;
      logic go_free;
      logic go_look;
   } stat_type;

endpackage

`default_nettype wire

@@ hdl/ring_slot_span_allocator.sv @@
// From acceptance, an item passes decode and any slot walk before the result register load.
// Alloc walks one slot per cycle over the span; recycle walks each freed slot.
// Lookup adds a state for the registered read of the slot store; other commands add none.
// One item at a time: the next item is taken the cycle after the result register loads.
// Reset: synchronous, clears pointers, then a pass over all 1024 slots marks every slot free;
// no item is accepted during that pass.
`timescale 1ns / 1ps
`default_nettype none

module ring_slot_span_allocator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rssa_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rssa_pkg::rsp_type      rsp_item
);

   rssa_pkg::ctl_type  ctl;
   rssa_pkg::stat_type stat;

   rssa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl),
      .stat      (stat)
   );

   rssa_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .rsp_item (rsp_item),
      .ctl      (ctl),
      .stat     (stat)
   );

`ifndef SYNTHESIS
   // A failed item never reports a position
   a_fail_no_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != rssa_pkg::ST_OK)) |-> (rsp_item.position == '0))
      else $error("failed item carries a position");

   // Only one slot store write source at a time
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.clear_step, ctl.alloc_step, ctl.free_step}))
      else $error("overlapping slot writes");

   // An accepted item is decoded in the next cycle
   a_decode_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> ctl.commit_dec)
      else $error("accepted item not decoded");

   // Pending count matches the reported pointers
   a_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.pending_count
                     == rssa_pkg::pos_type'(rsp_item.tail_now - rsp_item.head_now)))
      else $error("pending count mismatch");
`endif

endmodule

`default_nettype wire

@@ hdl/rssa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rssa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/rssa_ctrl.sv @@
// Sequencing state machine for the ring slot span allocator.
`timescale 1ns / 1ps
`default_nettype none

module rssa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rssa_pkg::ctl_type       ctl,
   input  wire rssa_pkg::stat_type stat
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_ALLOC  = 3'd3;
   localparam logic [2:0] S_FREE   = 3'd4;
   localparam logic [2:0] S_LCHK   = 3'd5;
   localparam logic [2:0] S_RESULT = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   // Sequence one item from decode through slot walk to result
   always_comb begin
      ctl          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_CLEAR: begin
            ctl.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.commit_dec = 1'b1;
            if (stat.go_alloc) begin
               state_in = S_ALLOC;
            end else if (stat.go_free) begin
               state_in = S_FREE;
            end else if (stat.go_look) begin
               state_in = S_LCHK;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_ALLOC: begin
            ctl.alloc_step = 1'b1;
            if (stat.alloc_last) begin
               state_in = S_RESULT;
            end
         end
         S_FREE: begin
            ctl.free_step = 1'b1;
            if (stat.free_last) begin
               state_in = S_RESULT;
            end
         end
         S_LCHK: begin
            ctl.look_commit = 1'b1;
            state_in        = S_RESULT;
         end
         S_RESULT: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/rssa_dpath.sv @@
// Pointers, slot store, range checks and result register.
`timescale 1ns / 1ps
`default_nettype none

module rssa_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rssa_pkg::req_type req_item,
   output rssa_pkg::rsp_type      rsp_item,
   input  wire rssa_pkg::ctl_type ctl,
   output rssa_pkg::stat_type     stat
);

   rssa_pkg::req_type       req_ff, req_in;
   rssa_pkg::addr_type      head_ff, head_in;
   rssa_pkg::addr_type      tail_ff, tail_in;
   rssa_pkg::addr_type      walk_ff, walk_in;
   rssa_pkg::cnt_type       left_ff, left_in;
   rssa_pkg::addr_type      dest_ff, dest_in;
   rssa_pkg::addr_type      pos_ff, pos_in;
   rssa_pkg::stat_code_type status_ff, status_in;
   rssa_pkg::rsp_type       rsp_ff, rsp_in;

   rssa_pkg::addr_type      walk_nx;
   rssa_pkg::addr_type      pend;
   rssa_pkg::addr_type      room;
   rssa_pkg::addr_type      idx;
   rssa_pkg::addr_type      dest;
   logic                    idx_big;
   logic                    empty;

   rssa_pkg::stat_code_type dec_status;
   rssa_pkg::addr_type      dec_pos;
   logic                    dec_set_tail;
   logic                    dec_zero;
   logic                    go_alloc, go_free, go_look;

   rssa_pkg::stat_code_type look_status;
   rssa_pkg::addr_type      look_pos;

   logic                    wr_en;
   rssa_pkg::entry_type     wr_entry;
   rssa_pkg::entry_type     rd_entry;
   logic [rssa_pkg::ENTRY_W-1:0] rd_raw;

   // Position lies between head and tail, both ends included
   function automatic logic in_incl(rssa_pkg::addr_type h, rssa_pkg::addr_type t,
                                    rssa_pkg::addr_type p);
      if (h <= t) begin
         return (p >= h) && (p <= t);
      end
      return (p <= t) || (p >= h);
   endfunction

   // Position lies in the occupied slots, head included, tail excluded
   function automatic logic in_occ(rssa_pkg::addr_type h, rssa_pkg::addr_type t,
                                   rssa_pkg::addr_type p);
      if (h < t) begin
         return (p >= h) && (p < t);
      end
      return (p < t) || (p >= h);
   endfunction

   // Ring arithmetic on the latched item
   assign walk_nx = walk_ff + rssa_pkg::addr_type'(1);
   assign pend    = tail_ff - head_ff;
   assign room    = rssa_pkg::addr_type'(rssa_pkg::POOL_SLOTS - 1) - pend;
   assign idx     = req_ff.slot_index[rssa_pkg::ADDR_W-1:0];
   assign dest    = rssa_pkg::addr_type'(rssa_pkg::wide_type'(req_ff.slot_index)
                                         + rssa_pkg::wide_type'(req_ff.sqe_count));
   assign idx_big = rssa_pkg::wide_type'(req_ff.slot_index)
                    >= rssa_pkg::wide_type'(rssa_pkg::POOL_SLOTS);
   assign empty   = (head_ff == tail_ff);

   // Decode the command against the current pointers
   always_comb begin
      dec_status   = rssa_pkg::ST_OK;
      dec_pos      = '0;
      dec_set_tail = 1'b0;
      dec_zero     = 1'b0;
      go_alloc     = 1'b0;
      go_free      = 1'b0;
      go_look      = 1'b0;
      case (req_ff.command)
         rssa_pkg::CMD_ALLOC: begin
            if (req_ff.sqe_count > rssa_pkg::cnt_type'(rssa_pkg::MAX_SPAN)) begin
               dec_status = rssa_pkg::ST_COUNT;
            end else if (rssa_pkg::wide_type'(req_ff.sqe_count)
                         > rssa_pkg::wide_type'(room)) begin
               dec_status = rssa_pkg::ST_FULL;
            end else begin
               dec_pos  = tail_ff;
               go_alloc = (req_ff.sqe_count != '0);
            end
         end
         rssa_pkg::CMD_RECYCLE: begin
            if (idx_big) begin
               dec_status = rssa_pkg::ST_INDEX;
            end else if (empty) begin
               dec_status = rssa_pkg::ST_EMPTY;
            end else if (!in_incl(head_ff, tail_ff, dest)) begin
               dec_status = rssa_pkg::ST_TARGET;
            end else begin
               go_free = (dest != head_ff);
            end
         end
         rssa_pkg::CMD_LOOKUP: begin
            if (idx_big) begin
               dec_status = rssa_pkg::ST_INDEX;
            end else if (empty) begin
               dec_status = rssa_pkg::ST_EMPTY;
            end else begin
               go_look = 1'b1;
            end
         end
         rssa_pkg::CMD_CHECK, rssa_pkg::CMD_ROLLBACK: begin
            if (idx_big) begin
               dec_status = rssa_pkg::ST_INDEX;
            end else if (!in_incl(head_ff, tail_ff, idx)) begin
               dec_status = rssa_pkg::ST_TARGET;
            end else begin
               dec_set_tail = (req_ff.command == rssa_pkg::CMD_ROLLBACK);
            end
         end
         rssa_pkg::CMD_RESET: begin
            dec_zero = 1'b1;
         end
         default: begin
            dec_status = rssa_pkg::ST_TARGET;
         end
      endcase
   end

   // Judge the owner entry read back for a lookup
   assign rd_entry = rssa_pkg::entry_type'(rd_raw);

   always_comb begin
      look_status = rssa_pkg::ST_OK;
      look_pos    = '0;
      if (rd_entry.free) begin
         look_status = rssa_pkg::ST_FREED;
      end else if (!in_occ(head_ff, tail_ff, idx)) begin
         look_status = rssa_pkg::ST_INDEX;
      end else if ((rd_entry.owner != idx) && !in_occ(head_ff, tail_ff, rd_entry.owner)) begin
         look_status = rssa_pkg::ST_OWNER;
      end else begin
         look_pos = rd_entry.owner;
      end
   end

   // Next values of pointers, walk counters and result
   always_comb begin
      req_in    = req_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      walk_in   = walk_ff;
      left_in   = left_ff;
      dest_in   = dest_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      rsp_in    = rsp_ff;
      if (ctl.latch_req) begin
         req_in = req_item;
      end
      if (ctl.clear_step) begin
         walk_in = walk_nx;
      end
      if (ctl.commit_dec) begin
         status_in = dec_status;
         pos_in    = dec_pos;
         walk_in   = (req_ff.command == rssa_pkg::CMD_RECYCLE) ? head_ff : tail_ff;
         left_in   = req_ff.sqe_count;
         dest_in   = dest;
         if (dec_set_tail) begin
            tail_in = idx;
         end
         if (dec_zero) begin
            head_in = '0;
            tail_in = '0;
         end
      end
      if (ctl.alloc_step) begin
         walk_in = walk_nx;
         left_in = left_ff - rssa_pkg::cnt_type'(1);
         if (stat.alloc_last) begin
            tail_in = walk_nx;
         end
      end
      if (ctl.free_step) begin
         walk_in = walk_nx;
         if (stat.free_last) begin
            head_in = dest_ff;
         end
      end
      if (ctl.look_commit) begin
         status_in = look_status;
         pos_in    = look_pos;
      end
      if (ctl.load_rsp) begin
         rsp_in.status        = status_ff;
         rsp_in.position      = rssa_pkg::pos_type'(pos_ff);
         rsp_in.head_now      = rssa_pkg::pos_type'(head_ff);
         rsp_in.tail_now      = rssa_pkg::pos_type'(tail_ff);
         rsp_in.pending_count = rssa_pkg::pos_type'(pend);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         walk_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         walk_ff <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      left_ff   <= left_in;
      dest_ff   <= dest_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // Stamp owners on alloc, mark free on recycle and clear pass
   assign wr_en          = ctl.clear_step || ctl.alloc_step || ctl.free_step;
   assign wr_entry.free  = !ctl.alloc_step;
   assign wr_entry.owner = ctl.alloc_step ? pos_ff : '0;

   rssa_ram #(
      .WIDTH (rssa_pkg::ENTRY_W),
      .DEPTH (rssa_pkg::POOL_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (walk_ff),
      .wr_data (wr_entry),
      .rd_addr (idx),
      .rd_data (rd_raw)
   );

   // Report walk ends and decode outcome to the controller
   assign stat.clear_last = (walk_ff == rssa_pkg::addr_type'(rssa_pkg::POOL_SLOTS - 1));
   assign stat.alloc_last = (left_ff == rssa_pkg::cnt_type'(1));
   assign stat.free_last  = (walk_nx == dest_ff);
   assign stat.go_alloc   = go_alloc;
   assign stat.go_free    = go_free;
   assign stat.go_look    = go_look;

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

@@ dv/ring_slot_span_allocator_tb.sv @@
// Self-checking testbench for the ring slot span allocator.
`timescale 1ns / 1ps

module ring_slot_span_allocator_tb;

   localparam logic [rssa_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [rssa_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int SETTLE_CYCLES = rssa_pkg::POOL_SLOTS + 76;
   localparam int LIMIT_CYCLES  =
      4 * (2000 + (RANDOM_ITEMS + 50) * (rssa_pkg::POOL_SLOTS + 64));

   logic              clock;
   logic              reset;
   logic              req_valid = 1'b0;
   logic              req_stall;
   rssa_pkg::req_type req_item  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rssa_pkg::rsp_type rsp_item;

   // Ring state as the block should hold it
   int                 ring_head_q;
   int                 ring_tail_q;
   rssa_pkg::addr_type span_owner [rssa_pkg::POOL_SLOTS];
   bit                 slot_idle  [rssa_pkg::POOL_SLOTS];

   rssa_pkg::req_type  pending_items [$];
   rssa_pkg::rsp_type  expected_rsp  [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int stall_window   = 0;
   int stall_mode     = 0;
   bit filling        = 1'b1;

   ring_slot_span_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int ring_fill();
      return (ring_tail_q + rssa_pkg::POOL_SLOTS - ring_head_q) % rssa_pkg::POOL_SLOTS;
   endfunction

   // Head and tail both count as inside
   function automatic bit spans_inclusive(int p);
      if (ring_head_q <= ring_tail_q) return (p >= ring_head_q) && (p <= ring_tail_q);
      return (p <= ring_tail_q) || (p >= ring_head_q);
   endfunction

   // Head counts, tail does not; only called on a ring that is not empty
   function automatic bit spans_occupied(int p);
      if (ring_head_q < ring_tail_q) return (p >= ring_head_q) && (p < ring_tail_q);
      return (p < ring_tail_q) || (p >= ring_head_q);
   endfunction

   // Apply one item to the ring and return the result it should produce
   function automatic rssa_pkg::rsp_type ring_apply(rssa_pkg::req_type r);
      rssa_pkg::rsp_type o;
      int idx, cnt, dest, walk, k, owner;
      o = '0;
      o.status = rssa_pkg::ST_OK;
      idx = int'(r.slot_index);
      cnt = int'(r.sqe_count);
      case (r.command)
         rssa_pkg::CMD_ALLOC: begin
            if (cnt > rssa_pkg::MAX_SPAN) begin
               o.status = rssa_pkg::ST_COUNT;
            end else if (cnt > rssa_pkg::POOL_SLOTS - 1 - ring_fill()) begin
               o.status = rssa_pkg::ST_FULL;
            end else begin
               o.position = rssa_pkg::pos_type'(ring_tail_q);
               walk = ring_tail_q;
               for (k = 0; k < cnt; k++) begin
                  span_owner[walk] = rssa_pkg::addr_type'(ring_tail_q);
                  slot_idle[walk]  = 1'b0;
                  walk = (walk + 1) % rssa_pkg::POOL_SLOTS;
               end
               ring_tail_q = walk;
            end
         end
         rssa_pkg::CMD_RECYCLE: begin
            if (idx >= rssa_pkg::POOL_SLOTS) begin
               o.status = rssa_pkg::ST_INDEX;
            end else if (ring_head_q == ring_tail_q) begin
               o.status = rssa_pkg::ST_EMPTY;
            end else begin
               dest = (idx + cnt) % rssa_pkg::POOL_SLOTS;
               if (!spans_inclusive(dest)) begin
                  o.status = rssa_pkg::ST_TARGET;
               end else begin
                  walk = ring_head_q;
                  while (walk != dest) begin
                     slot_idle[walk] = 1'b1;
                     walk = (walk + 1) % rssa_pkg::POOL_SLOTS;
                  end
                  ring_head_q = walk;
               end
            end
         end
         rssa_pkg::CMD_LOOKUP: begin
            if (idx >= rssa_pkg::POOL_SLOTS) begin
               o.status = rssa_pkg::ST_INDEX;
            end else if (ring_head_q == ring_tail_q) begin
               o.status = rssa_pkg::ST_EMPTY;
            end else if (slot_idle[idx]) begin
               o.status = rssa_pkg::ST_FREED;
            end else if (!spans_occupied(idx)) begin
               o.status = rssa_pkg::ST_INDEX;
            end else begin
               owner = int'(span_owner[idx]);
               if (owner != idx && !spans_occupied(owner)) o.status = rssa_pkg::ST_OWNER;
               else o.position = rssa_pkg::pos_type'(owner);
            end
         end
         rssa_pkg::CMD_CHECK, rssa_pkg::CMD_ROLLBACK: begin
            if (idx >= rssa_pkg::POOL_SLOTS) o.status = rssa_pkg::ST_INDEX;
            else if (!spans_inclusive(idx)) o.status = rssa_pkg::ST_TARGET;
            else if (r.command == rssa_pkg::CMD_ROLLBACK) ring_tail_q = idx;
         end
         rssa_pkg::CMD_RESET: begin
            ring_head_q = 0;
            ring_tail_q = 0;
         end
         default: begin
            o.status = rssa_pkg::ST_TARGET;
         end
      endcase
      o.head_now      = rssa_pkg::pos_type'(ring_head_q);
      o.tail_now      = rssa_pkg::pos_type'(ring_tail_q);
      o.pending_count = rssa_pkg::pos_type'(ring_fill());
      return o;
   endfunction

   function automatic void queue_item(logic [rssa_pkg::CMD_W-1:0] cmd, int idx, int cnt);
      rssa_pkg::req_type r;
      r.command    = cmd;
      r.slot_index = rssa_pkg::IDX_W'(idx);
      r.sqe_count  = rssa_pkg::CNT_W'(cnt);
      pending_items.push_back(r);
   endfunction

   // Build the next item from the current ring, mostly well formed
   function automatic rssa_pkg::req_type next_random_item();
      rssa_pkg::req_type r;
      int fill, pick, alloc_cut, recycle_cut, lookup_cut, check_cut, d, j, lo, k;
      fill = ring_fill();
      alloc_cut   = filling ? 60 : 30;
      recycle_cut = filling ? 68 : 60;
      lookup_cut  = filling ? 88 : 85;
      check_cut   = filling ? 94 : 93;
      r.command    = rssa_pkg::CMD_ALLOC;
      r.slot_index = rssa_pkg::IDX_W'($urandom);
      r.sqe_count  = rssa_pkg::CNT_W'($urandom_range(0, rssa_pkg::MAX_SPAN));
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         // raw noise over every field
         r.command   = rssa_pkg::CMD_W'($urandom);
         r.sqe_count = rssa_pkg::CNT_W'($urandom);
         if (r.command == CMD_UNUSED_LO || r.command == CMD_UNUSED_HI ||
             $urandom_range(0, 1) == 0)
            r.command = CMD_UNUSED_LO + rssa_pkg::CMD_W'($urandom_range(0, 1));
      end else if (pick < 3) begin
         r.command = rssa_pkg::CMD_RESET;
      end else if (pick < alloc_cut) begin
         if ($urandom_range(0, 19) == 0)
            r.sqe_count = rssa_pkg::CNT_W'($urandom_range(rssa_pkg::MAX_SPAN + 1, 255));
      end else if (pick < recycle_cut) begin
         r.command = rssa_pkg::CMD_RECYCLE;
         if ($urandom_range(0, 4) != 0) begin
            // split a move of d slots into start and count
            d  = ($urandom_range(0, 32) == 0) ? fill
                                              : $urandom_range(0, (fill < 48) ? fill : 48);
            lo = (d > 255) ? d - 255 : 0;
            j  = $urandom_range(lo, d);
            r.slot_index = rssa_pkg::IDX_W'((ring_head_q + j) % rssa_pkg::POOL_SLOTS);
            r.sqe_count  = rssa_pkg::CNT_W'(d - j);
         end else begin
            r.sqe_count = rssa_pkg::CNT_W'($urandom);
            if ($urandom_range(0, 3) != 0)
               r.slot_index = rssa_pkg::IDX_W'($urandom_range(0, rssa_pkg::POOL_SLOTS - 1));
         end
      end else if (pick < lookup_cut) begin
         r.command = rssa_pkg::CMD_LOOKUP;
         if (fill > 0 && $urandom_range(0, 19) < 17)
            r.slot_index = rssa_pkg::IDX_W'((ring_head_q + $urandom_range(0, fill - 1))
                                            % rssa_pkg::POOL_SLOTS);
         else if ($urandom_range(0, 3) != 0)
            r.slot_index = rssa_pkg::IDX_W'($urandom_range(0, rssa_pkg::POOL_SLOTS - 1));
      end else if (pick < check_cut) begin
         r.command = rssa_pkg::CMD_CHECK;
         if ($urandom_range(0, 3) != 0)
            r.slot_index = rssa_pkg::IDX_W'((ring_head_q + $urandom_range(0, fill + 4))
                                            % rssa_pkg::POOL_SLOTS);
      end else begin
         r.command = rssa_pkg::CMD_ROLLBACK;
         if ($urandom_range(0, 4) != 0) begin
            k = $urandom_range(0, (fill < 8) ? fill : 8);
            r.slot_index = rssa_pkg::IDX_W'((ring_tail_q - k + rssa_pkg::POOL_SLOTS)
                                            % rssa_pkg::POOL_SLOTS);
         end else if ($urandom_range(0, 1) == 0) begin
            r.slot_index = rssa_pkg::IDX_W'($urandom_range(0, rssa_pkg::POOL_SLOTS - 1));
         end
      end
      return r;
   endfunction

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   // Stimulus: directed corners first, then random items one at a time
   initial begin
      int n;
      ring_head_q = 0;
      ring_tail_q = 0;
      for (n = 0; n < rssa_pkg::POOL_SLOTS; n++) begin
         span_owner[n] = '0;
         slot_idle[n]  = 1'b1;
      end

      queue_item(rssa_pkg::CMD_LOOKUP, 0, 0);           // empty ring
      queue_item(rssa_pkg::CMD_RECYCLE, 0, 0);          // recycle on empty ring
      queue_item(rssa_pkg::CMD_ALLOC, 16'hFFFF, 0);     // zero-length span
      queue_item(rssa_pkg::CMD_ALLOC, 0, rssa_pkg::MAX_SPAN + 1); // span too long
      queue_item(rssa_pkg::CMD_ALLOC, 0, 255);
      queue_item(rssa_pkg::CMD_ALLOC, 0, rssa_pkg::MAX_SPAN);
      queue_item(rssa_pkg::CMD_ALLOC, 0, 5);
      queue_item(rssa_pkg::CMD_LOOKUP, 18, 0);          // owner is span start
      queue_item(rssa_pkg::CMD_LOOKUP, 21, 0);          // never stamped slot
      queue_item(rssa_pkg::CMD_LOOKUP, 16'hFFFF, 0);
      queue_item(rssa_pkg::CMD_LOOKUP, rssa_pkg::POOL_SLOTS, 0);
      queue_item(rssa_pkg::CMD_CHECK, 21, 0);           // tail is inside
      queue_item(rssa_pkg::CMD_CHECK, 22, 0);
      queue_item(rssa_pkg::CMD_CHECK, 16'hFFFF, 0);
      queue_item(rssa_pkg::CMD_RECYCLE, 16'hFFFF, 0);
      queue_item(rssa_pkg::CMD_RECYCLE, 10, 100);       // target outside the ring
      queue_item(rssa_pkg::CMD_RECYCLE, 0, 4);
      queue_item(rssa_pkg::CMD_LOOKUP, 2, 0);           // freed slot
      queue_item(rssa_pkg::CMD_ROLLBACK, 18, 0);
      queue_item(rssa_pkg::CMD_LOOKUP, 19, 0);          // stamped but past the tail
      queue_item(rssa_pkg::CMD_ROLLBACK, 30, 0);        // rollback outside the ring
      queue_item(rssa_pkg::CMD_ROLLBACK, 16'h8000, 0);
      queue_item(rssa_pkg::CMD_RECYCLE, 17, 0);
      queue_item(rssa_pkg::CMD_LOOKUP, 17, 0);          // owner start already freed
      queue_item(CMD_UNUSED_LO, 16'h5A5A, 8'hA5);
      queue_item(CMD_UNUSED_HI, 0, 0);
      queue_item(rssa_pkg::CMD_RESET, 0, 0);
      queue_item(rssa_pkg::CMD_ALLOC, 0, 3);
      queue_item(rssa_pkg::CMD_LOOKUP, 1, 0);
      queue_item(rssa_pkg::CMD_RECYCLE, 0, 3);          // drain to empty

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         do @(negedge clock); while (pending_items.size() != 0);
         if (ring_fill() >= rssa_pkg::POOL_SLOTS - 4) filling = 1'b0;
         else if (ring_fill() < 16) filling = 1'b1;
         pending_items.push_back(next_random_item());
      end

      // drain, then let any stray result show up
      do @(negedge clock); while (pending_items.size() != 0 || expected_rsp.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("** ring_slot_span_allocator: PASSED **");
      end else begin
         $display("** ring_slot_span_allocator: FAILED **");
      end
      $finish;
   end

   // Drive items in bursts; hold a stalled item
   always @(posedge clock) begin
      rssa_pkg::req_type taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken = pending_items.pop_front();
            expected_rsp.push_back(ring_apply(taken));
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_valid <= 1'b1;
               req_item  <= pending_items[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Check results in order and stall on a windowed pattern
   always @(posedge clock) begin
      rssa_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result item: status %0d position %0d",
                   rsp_item.status, rsp_item.position);
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("status", int'(want.status), int'(rsp_item.status));
            check_field("position", int'(want.position), int'(rsp_item.position));
            check_field("head_now", int'(want.head_now), int'(rsp_item.head_now));
            check_field("tail_now", int'(want.tail_now), int'(rsp_item.tail_now));
            check_field("pending_count", int'(want.pending_count),
                        int'(rsp_item.pending_count));
         end
      end
      stall_window++;
      if (stall_window >= 256) begin
         stall_window = 0;
         stall_mode   = $urandom_range(0, 3);
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_window[4];
      endcase
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("** ring_slot_span_allocator: FAILED **");
         $finish;
      end
   end

endmodule

@@ sim.f @@
hdl/rssa_pkg.sv
hdl/rssa_ram.sv
hdl/rssa_ctrl.sv
hdl/rssa_dpath.sv
hdl/ring_slot_span_allocator.sv
dv/ring_slot_span_allocator_tb.sv
